@@ rtl/nav_frame_sync_checksum_defines.svh @@
// assertion macros for the frame sync checksum block
`ifndef NAV_FRAME_SYNC_CHECKSUM_DEFINES_SVH
`define NAV_FRAME_SYNC_CHECKSUM_DEFINES_SVH

// clocked assertion, off while reset is asserted
`define NFSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// clocked assertion, also checked during reset
`define NFSC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ rtl/nfsc_pkg.sv @@
`timescale 1ns / 1ps
package nfsc_pkg;

    localparam int FRAME_BYTES_DEF = 60;
    localparam int BYTE_W          = 8;
    localparam int WORD_W          = 16;
    localparam int KIND_W          = 2;
    localparam int WIDX_W          = 5;

    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h3a;

    typedef enum logic [KIND_W-1:0] {
        KIND_WORD    = 2'd0,
        KIND_BAD_HDR = 2'd1,
        KIND_BAD_SUM = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_JUDGE,
        ST_STATUS,
        ST_SLIDE,
        ST_RD_LO,
        ST_RD_HI,
        ST_WORD
    } t_state;

endpackage

@@ rtl/nav_frame_sync_checksum.sv @@
`timescale 1ns / 1ps
// nav_frame_sync_checksum: byte-serial frame synchronizer and checksum checker
// input channel: i_in_valid / o_in_ready carry one i_rx_byte per beat
// output channel: o_out_valid / i_out_ready carry one result per beat
// config: i_cfg_we writes i_cfg_data into the sync value; the user must write it
// only while the block is idle, which the block itself does not enforce
// a byte that does not complete the frame store is taken; the byte that fills it
// starts a scan over the single read port of the store, then the frame is judged
// good frame: FRAME_BYTES/2 word beats, each from two store reads and the output
// load, then the block is idle again
// bad frame: one status beat, then a slide of the kept bytes to the front of the
// store at one byte per cycle, from the first sync byte after byte 0
// o_in_ready is high only while the sequencer is idle
// one output register holds a result; a stalled receiver holds the sequencer at
// its next load, while bytes that only fill the store are still taken
// reset empties the store, clears the output and sets the sync value to 0x3a
module nav_frame_sync_checksum #(
    parameter int FRAME_BYTES = nfsc_pkg::FRAME_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [nfsc_pkg::BYTE_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [nfsc_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [nfsc_pkg::KIND_W-1:0] o_kind,
    output logic [nfsc_pkg::WORD_W-1:0] o_frame_word,
    output logic [nfsc_pkg::WIDX_W-1:0] o_word_index,
    output logic                        o_last,
    output logic [nfsc_pkg::WORD_W-1:0] o_received_sum,
    output logic [nfsc_pkg::WORD_W-1:0] o_computed_sum
);

    import nfsc_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int CW = $clog2(FRAME_BYTES + 1);
    localparam int NW = FRAME_BYTES / 2;

    t_state r_state, n_state;

    logic [BYTE_W-1:0] r_sync_value;
    logic [CW-1:0]     r_fill, n_fill;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_wr_pend, n_wr_pend;
    logic [AW-1:0]     r_wr_addr, n_wr_addr;
    logic              r_b0_ok, n_b0_ok;
    logic              r_hdr_ok, n_hdr_ok;
    logic              r_found, n_found;
    logic [CW-1:0]     r_pos, n_pos;
    logic [BYTE_W-1:0] r_lo, n_lo;
    logic [WORD_W-1:0] r_csum, n_csum;
    logic [WORD_W-1:0] r_rsum, n_rsum;

    logic              r_out_valid, n_out_valid;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [WORD_W-1:0] r_word, n_word;
    logic [WIDX_W-1:0] r_widx, n_widx;
    logic              r_last, n_last;
    logic [WORD_W-1:0] r_orsum, n_orsum;
    logic [WORD_W-1:0] r_ocsum, n_ocsum;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] rd_data;

    logic              in_acc;
    logic              out_free;
    logic [CW-1:0]     scan_pos;
    logic [CW-1:0]     w_lo_addr;
    logic [CW-1:0]     w_hi_addr;
    logic              word_last;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign scan_pos   = r_cnt - CW'(1);
    assign w_lo_addr  = r_cnt << 1;
    assign w_hi_addr  = w_lo_addr + CW'(1);
    assign word_last  = (r_cnt == CW'(NW - 1));

    nfsc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && r_fill == CW'(FRAME_BYTES - 1)) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_cnt == CW'(FRAME_BYTES)) n_state = ST_JUDGE;
            end
            ST_JUDGE: begin
                if (r_hdr_ok && r_rsum == r_csum) n_state = ST_RD_LO;
                else n_state = ST_STATUS;
            end
            ST_STATUS: begin
                if (out_free) n_state = ST_SLIDE;
            end
            ST_SLIDE: begin
                if (r_cnt == CW'(FRAME_BYTES)) n_state = ST_IDLE;
            end
            ST_RD_LO: n_state = ST_RD_HI;
            ST_RD_HI: n_state = ST_WORD;
            ST_WORD: begin
                if (out_free) n_state = word_last ? ST_IDLE : ST_RD_LO;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_wr_pend   = r_wr_pend;
        n_wr_addr   = r_wr_addr;
        n_b0_ok     = r_b0_ok;
        n_hdr_ok    = r_hdr_ok;
        n_found     = r_found;
        n_pos       = r_pos;
        n_lo        = r_lo;
        n_csum      = r_csum;
        n_rsum      = r_rsum;
        n_out_valid = r_out_valid && !i_out_ready;
        n_kind      = r_kind;
        n_word      = r_word;
        n_widx      = r_widx;
        n_last      = r_last;
        n_orsum     = r_orsum;
        n_ocsum     = r_ocsum;
        ram_we      = 1'b0;
        ram_waddr   = r_fill[AW-1:0];
        ram_wdata   = i_rx_byte;
        ram_re      = 1'b0;
        ram_raddr   = r_cnt[AW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    ram_we  = 1'b1;
                    n_fill  = r_fill + CW'(1);
                    n_cnt   = '0;
                    n_csum  = '0;
                    n_found = 1'b0;
                    n_pos   = CW'(FRAME_BYTES);
                end
            end
            ST_SCAN: begin
                if (r_cnt != CW'(FRAME_BYTES)) begin
                    ram_re = 1'b1;
                    n_cnt  = r_cnt + CW'(1);
                end
                if (r_cnt != '0) begin
                    if (scan_pos == CW'(0)) n_b0_ok = (rd_data == r_sync_value);
                    if (scan_pos == CW'(1)) n_hdr_ok = r_b0_ok && (rd_data == '0);
                    if (!scan_pos[0]) begin
                        n_lo = rd_data;
                    end else if (scan_pos >= CW'(3) && scan_pos < CW'(FRAME_BYTES - 2)) begin
                        n_csum = r_csum + {rd_data, r_lo};
                    end
                    if (scan_pos == CW'(FRAME_BYTES - 2)) n_rsum[7:0] = rd_data;
                    if (scan_pos == CW'(FRAME_BYTES - 1)) n_rsum[15:8] = rd_data;
                    if (scan_pos != CW'(0) && !r_found && rd_data == r_sync_value) begin
                        n_found = 1'b1;
                        n_pos   = scan_pos;
                    end
                end
            end
            ST_JUDGE: begin
                n_cnt = '0;
            end
            ST_STATUS: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = r_hdr_ok ? KIND_BAD_SUM : KIND_BAD_HDR;
                    n_word      = '0;
                    n_widx      = '0;
                    n_last      = 1'b1;
                    n_orsum     = r_rsum;
                    n_ocsum     = r_csum;
                    n_cnt       = r_pos;
                    n_wr_addr   = '0;
                    n_wr_pend   = 1'b0;
                    n_fill      = CW'(FRAME_BYTES) - r_pos;
                end
            end
            ST_SLIDE: begin
                if (r_cnt != CW'(FRAME_BYTES)) begin
                    ram_re    = 1'b1;
                    n_cnt     = r_cnt + CW'(1);
                    n_wr_pend = 1'b1;
                end else begin
                    n_wr_pend = 1'b0;
                end
                if (r_wr_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wr_addr;
                    ram_wdata = rd_data;
                    n_wr_addr = r_wr_addr + AW'(1);
                end
            end
            ST_RD_LO: begin
                ram_re    = 1'b1;
                ram_raddr = w_lo_addr[AW-1:0];
            end
            ST_RD_HI: begin
                ram_re    = 1'b1;
                ram_raddr = w_hi_addr[AW-1:0];
                n_lo      = rd_data;
            end
            ST_WORD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_WORD;
                    n_word      = {rd_data, r_lo};
                    n_widx      = WIDX_W'(r_cnt);
                    n_last      = word_last;
                    n_orsum     = r_rsum;
                    n_ocsum     = r_csum;
                    n_cnt       = r_cnt + CW'(1);
                    if (word_last) n_fill = '0;
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_sync_value <= SYNC_RESET;
            r_fill       <= '0;
            r_cnt        <= '0;
            r_wr_pend    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_we) r_sync_value <= i_cfg_data;
            r_fill       <= n_fill;
            r_cnt        <= n_cnt;
            r_wr_pend    <= n_wr_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= n_wr_addr;
        r_b0_ok   <= n_b0_ok;
        r_hdr_ok  <= n_hdr_ok;
        r_found   <= n_found;
        r_pos     <= n_pos;
        r_lo      <= n_lo;
        r_csum    <= n_csum;
        r_rsum    <= n_rsum;
        r_kind    <= n_kind;
        r_word    <= n_word;
        r_widx    <= n_widx;
        r_last    <= n_last;
        r_orsum   <= n_orsum;
        r_ocsum   <= n_ocsum;
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_frame_word   = r_word;
    assign o_word_index   = r_widx;
    assign o_last         = r_last;
    assign o_received_sum = r_orsum;
    assign o_computed_sum = r_ocsum;

endmodule

@@ rtl/nfsc_ram.sv @@
`timescale 1ns / 1ps
module nfsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/nfsc_checker.sv @@
`timescale 1ns / 1ps
`include "nav_frame_sync_checksum_defines.svh"
module nfsc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [nfsc_pkg::KIND_W-1:0] o_kind,
    input logic [nfsc_pkg::WORD_W-1:0] o_frame_word,
    input logic [nfsc_pkg::WIDX_W-1:0] o_word_index,
    input logic                        o_last,
    input logic [nfsc_pkg::WORD_W-1:0] o_received_sum,
    input logic [nfsc_pkg::WORD_W-1:0] o_computed_sum
);

    import nfsc_pkg::*;

    // a stalled result beat keeps its payload
    `NFSC_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind) && $stable(o_frame_word) && $stable(o_word_index) && $stable(o_last), "output beat changed while stalled")

    `NFSC_ASSERT_RST(a_rst_clear, !i_rst_n |=> !o_out_valid, "output valid after reset")

    // status beats are single and carry no word
    `NFSC_ASSERT(a_status_form, o_out_valid && o_kind != KIND_WORD |-> o_last && o_frame_word == '0 && o_word_index == '0, "malformed status beat")

    // a good frame always has matching sums
    `NFSC_ASSERT(a_good_sum, o_out_valid && o_kind == KIND_WORD |-> o_received_sum == o_computed_sum, "frame word with checksum mismatch")

endmodule

bind nav_frame_sync_checksum nfsc_checker u_nfsc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_kind         (o_kind),
    .o_frame_word   (o_frame_word),
    .o_word_index   (o_word_index),
    .o_last         (o_last),
    .o_received_sum (o_received_sum),
    .o_computed_sum (o_computed_sum)
);
